@@ design/lfj_pkg.sv @@
// Shared types and constants for the line full-justification block.
// Used by every module of the block; no dependencies.
package lfj_pkg;

  localparam int LINE_MAX     = 64;
  localparam int ADDR_W       = $clog2(LINE_MAX);
  localparam int CNT_W        = $clog2(LINE_MAX + 1);
  localparam int STEP_W       = $clog2(CNT_W);
  localparam int CHAR_W       = 8;
  localparam int TW_W         = 7;
  localparam int OUT_MAX      = 64;
  localparam int TARGET_RESET = 60;
  localparam int LINEQ_DEPTH  = 2;
  localparam int LQ_PTR_W     = $clog2(LINEQ_DEPTH);
  localparam int LQ_CNT_W     = $clog2(LINEQ_DEPTH + 1);

  localparam logic [CHAR_W-1:0] SPACE_CHAR = CHAR_W'(32);

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_LONG   = 2'd1,
    ST_NOWORD = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_DIV,
    BK_FETCH,
    BK_EMIT,
    BK_ERR
  } back_state_e;

  typedef struct packed {
    status_e          status;
    logic [CNT_W-1:0] len;
    logic [CNT_W-1:0] spaces;
    logic [CNT_W-1:0] tgt;
  } desc_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [CHAR_W-1:0] data;
  } wr_t;

endpackage

@@ design/lfj_front.sv @@
// Front end: accepts characters, counts length and spaces, classifies the line.
// Holds the target width register. Depends on lfj_pkg.
module lfj_front import lfj_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  logic [CHAR_W-1:0] char_in_i,
  input  logic              is_last_i,
  input  logic              cfg_we_i,
  input  logic [TW_W-1:0]   cfg_wdata_i,
  input  logic              lq_full_i,
  output wr_t               wr_o,
  output logic              desc_push_o,
  output desc_t             desc_o
);

  logic [TW_W-1:0]  tw_q;
  logic [CNT_W-1:0] len_q, len_d;
  logic [CNT_W-1:0] sp_q, sp_d;
  logic             ovf_q, ovf_d;
  logic             accept, has_room;
  logic [CNT_W-1:0] len_new, sp_new, tgt;
  logic             ovf_new;

  assign full     = lq_full_i;
  assign accept   = push && !lq_full_i;
  assign has_room = len_q < CNT_W'(LINE_MAX);

  always_comb begin
    len_new = has_room ? len_q + CNT_W'(1) : len_q;
    sp_new  = (has_room && char_in_i == SPACE_CHAR) ? sp_q + CNT_W'(1) : sp_q;
    ovf_new = ovf_q || !has_room;
    tgt     = (tw_q > TW_W'(OUT_MAX)) ? CNT_W'(OUT_MAX) : CNT_W'(tw_q);

    desc_o.len    = len_new;
    desc_o.spaces = sp_new;
    desc_o.tgt    = tgt;
    if (ovf_new || len_new > tgt) begin
      desc_o.status = ST_LONG;
    end else if (sp_new == '0) begin
      desc_o.status = ST_NOWORD;
    end else begin
      desc_o.status = ST_OK;
    end
    desc_push_o = accept && is_last_i;

    wr_o.we   = accept && has_room;
    wr_o.addr = len_q[ADDR_W-1:0];
    wr_o.data = char_in_i;

    len_d = len_q;
    sp_d  = sp_q;
    ovf_d = ovf_q;
    if (accept) begin
      if (is_last_i) begin
        len_d = '0;
        sp_d  = '0;
        ovf_d = 1'b0;
      end else begin
        len_d = len_new;
        sp_d  = sp_new;
        ovf_d = ovf_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tw_q  <= TW_W'(TARGET_RESET);
      len_q <= '0;
      sp_q  <= '0;
      ovf_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        tw_q <= cfg_wdata_i;
      end
      len_q <= len_d;
      sp_q  <= sp_d;
      ovf_q <= ovf_d;
    end
  end

endmodule

@@ design/lfj_lineq.sv @@
// Two-line queue between front and back: line buffer banks plus line descriptors.
// Character memory with registered read. Depends on lfj_pkg.
module lfj_lineq import lfj_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  wr_t               wr_i,
  input  logic              push_i,
  input  desc_t             desc_i,
  output logic              full_o,
  output logic              valid_o,
  output desc_t             head_o,
  input  logic              pop_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [CHAR_W-1:0] rdata_o
);

  logic [CHAR_W-1:0]   mem [LINEQ_DEPTH*LINE_MAX];
  desc_t               desc_q [LINEQ_DEPTH];
  logic [LQ_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [LQ_CNT_W-1:0] cnt_q;
  logic [CHAR_W-1:0]   rdata_q;

  assign full_o  = cnt_q == LQ_CNT_W'(LINEQ_DEPTH);
  assign valid_o = cnt_q != '0;
  assign head_o  = desc_q[rd_ptr_q];
  assign rdata_o = rdata_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem[{wr_ptr_q, wr_i.addr}] <= wr_i.data;
    end
    rdata_q <= mem[{rd_ptr_q, raddr_i}];
    if (push_i) begin
      desc_q[wr_ptr_q] <= desc_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + LQ_PTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + LQ_PTR_W'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + LQ_CNT_W'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - LQ_CNT_W'(1);
      end
    end
  end

endmodule

@@ design/lfj_back.sv @@
// Back end: divides padding over the gaps and emits the justified line.
// Serial divider, emit sequencer and output register. Depends on lfj_pkg.
module lfj_back import lfj_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              desc_valid_i,
  input  desc_t             desc_i,
  output logic              desc_pop_o,
  output logic [ADDR_W-1:0] raddr_o,
  input  logic [CHAR_W-1:0] rdata_i,
  input  logic              pop,
  output logic              empty,
  output logic [CHAR_W-1:0] char_out_o,
  output logic              end_of_line_o,
  output logic [1:0]        status_o,
  output logic [TW_W-1:0]   added_spaces_o
);

  back_state_e       state_q, state_d;
  logic [ADDR_W-1:0] i_q, i_d;
  logic [CNT_W-1:0]  k_q, k_d, j_q, j_d, gap_q, gap_d;
  logic [CNT_W-1:0]  quo_q, quo_d;
  logic [CNT_W:0]    rem_q, rem_d;
  logic [STEP_W-1:0] step_q, step_d;

  logic              ov_q, ov_d;
  logic [CHAR_W-1:0] oc_q, oc_d;
  logic              oe_q, oe_d;
  status_e           os_q, os_d;
  logic [TW_W-1:0]   oa_q, oa_d;

  logic              slot_free, is_sp, last_res;
  logic [CNT_W:0]    shifted;
  logic [CNT_W-1:0]  n_sp, added;

  assign slot_free      = !ov_q || pop;
  assign empty          = !ov_q;
  assign char_out_o     = oc_q;
  assign end_of_line_o  = oe_q;
  assign status_o       = os_q;
  assign added_spaces_o = oa_q;
  assign raddr_o        = i_q;

  always_comb begin
    state_d    = state_q;
    i_d        = i_q;
    k_d        = k_q;
    j_d        = j_q;
    gap_d      = gap_q;
    quo_d      = quo_q;
    rem_d      = rem_q;
    step_d     = step_q;
    desc_pop_o = 1'b0;
    ov_d       = ov_q && !pop;
    oc_d       = oc_q;
    oe_d       = oe_q;
    os_d       = os_q;
    oa_d       = oa_q;

    shifted  = {rem_q[CNT_W-1:0], quo_q[CNT_W-1]};
    is_sp    = rdata_i == SPACE_CHAR;
    last_res = k_q == desc_i.tgt - CNT_W'(1);
    n_sp     = quo_q + ((gap_q < rem_q[CNT_W-1:0]) ? CNT_W'(1) : CNT_W'(0));
    added    = desc_i.tgt - desc_i.len;

    unique case (state_q)
      BK_IDLE: begin
        i_d    = '0;
        k_d    = '0;
        j_d    = '0;
        gap_d  = '0;
        rem_d  = '0;
        step_d = '0;
        quo_d  = desc_i.tgt - desc_i.len + desc_i.spaces;
        if (desc_valid_i) begin
          state_d = (desc_i.status == ST_OK) ? BK_DIV : BK_ERR;
        end
      end
      BK_DIV: begin
        if (shifted >= {1'b0, desc_i.spaces}) begin
          rem_d = shifted - {1'b0, desc_i.spaces};
          quo_d = {quo_q[CNT_W-2:0], 1'b1};
        end else begin
          rem_d = shifted;
          quo_d = {quo_q[CNT_W-2:0], 1'b0};
        end
        step_d = step_q + STEP_W'(1);
        if (step_q == STEP_W'(CNT_W - 1)) begin
          state_d = BK_FETCH;
        end
      end
      BK_FETCH: begin
        state_d = BK_EMIT;
      end
      BK_EMIT: begin
        if (slot_free) begin
          ov_d = 1'b1;
          oc_d = is_sp ? SPACE_CHAR : rdata_i;
          oe_d = last_res;
          os_d = ST_OK;
          oa_d = TW_W'(added);
          k_d  = k_q + CNT_W'(1);
          if (last_res) begin
            desc_pop_o = 1'b1;
            state_d    = BK_IDLE;
          end else if (!is_sp) begin
            i_d     = i_q + ADDR_W'(1);
            state_d = BK_FETCH;
          end else if (j_q + CNT_W'(1) == n_sp) begin
            j_d     = '0;
            gap_d   = gap_q + CNT_W'(1);
            i_d     = i_q + ADDR_W'(1);
            state_d = BK_FETCH;
          end else begin
            j_d = j_q + CNT_W'(1);
          end
        end
      end
      BK_ERR: begin
        if (slot_free) begin
          ov_d       = 1'b1;
          oc_d       = '0;
          oe_d       = 1'b1;
          os_d       = desc_i.status;
          oa_d       = '0;
          desc_pop_o = 1'b1;
          state_d    = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q    <= i_d;
    k_q    <= k_d;
    j_q    <= j_d;
    gap_q  <= gap_d;
    quo_q  <= quo_d;
    rem_q  <= rem_d;
    step_q <= step_d;
    oc_q   <= oc_d;
    oe_q   <= oe_d;
    os_q   <= os_d;
    oa_q   <= oa_d;
  end

endmodule

@@ design/line_full_justify.sv @@
// Top level of the line full-justification block.
// Instantiates lfj_front, lfj_lineq and lfj_back; depends on lfj_pkg.
//
// Input channel: push/full with char_in_i and is_last_i, one character per
// transaction; a line ends at the character with is_last_i set. Characters
// are taken one per cycle while full is low.
// Result channel: empty/pop; the oldest result shows on the result ports
// while empty is low. An ok line yields exactly target-width results, an
// unjustifiable line (too long, store overflow, or no space) yields one
// error result with char_out_o zero. end_of_line_o marks a line's last result.
// Configuration: cfg_we_i/cfg_wdata_i write the target width (reset 60,
// values above 64 count as 64); write it only while the block is idle.
// After the last character, a line passes a setup state and the serial
// divider (one quotient bit per cycle); then each non-space character
// takes a memory read and an emit, and each input space takes a memory
// read and then emits the spaces of its gap. Two line
// buffers let the next line load while the previous one is emitted; full
// rises when both hold lines. A stalled receiver holds the output register
// and freezes emission. Reset empties both buffers and the output register.
module line_full_justify import lfj_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  logic [CHAR_W-1:0] char_in_i,
  input  logic              is_last_i,
  input  logic              cfg_we_i,
  input  logic [TW_W-1:0]   cfg_wdata_i,
  output logic              empty,
  input  logic              pop,
  output logic [CHAR_W-1:0] char_out_o,
  output logic              end_of_line_o,
  output logic [1:0]        status_o,
  output logic [TW_W-1:0]   added_spaces_o
);

  wr_t               wr;
  logic              desc_push, desc_pop, lq_full, lq_valid;
  desc_t             desc_new, desc_head;
  logic [ADDR_W-1:0] raddr;
  logic [CHAR_W-1:0] rdata;

  lfj_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .char_in_i   (char_in_i),
    .is_last_i   (is_last_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .lq_full_i   (lq_full),
    .wr_o        (wr),
    .desc_push_o (desc_push),
    .desc_o      (desc_new)
  );

  lfj_lineq u_lineq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (wr),
    .push_i  (desc_push),
    .desc_i  (desc_new),
    .full_o  (lq_full),
    .valid_o (lq_valid),
    .head_o  (desc_head),
    .pop_i   (desc_pop),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  lfj_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .desc_valid_i   (lq_valid),
    .desc_i         (desc_head),
    .desc_pop_o     (desc_pop),
    .raddr_o        (raddr),
    .rdata_i        (rdata),
    .pop            (pop),
    .empty          (empty),
    .char_out_o     (char_out_o),
    .end_of_line_o  (end_of_line_o),
    .status_o       (status_o),
    .added_spaces_o (added_spaces_o)
  );

endmodule

@@ design/lfj_checker.sv @@
// Port-level checks for line_full_justify, attached by bind.
// Depends on lfj_pkg and the top level's port list.
module lfj_checker import lfj_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              push,
  input logic              full,
  input logic [CHAR_W-1:0] char_in_i,
  input logic              is_last_i,
  input logic              cfg_we_i,
  input logic [TW_W-1:0]   cfg_wdata_i,
  input logic              empty,
  input logic              pop,
  input logic [CHAR_W-1:0] char_out_o,
  input logic              end_of_line_o,
  input logic [1:0]        status_o,
  input logic [TW_W-1:0]   added_spaces_o
);

  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty)
    else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> $stable(char_out_o) && $stable(end_of_line_o) &&
                       $stable(status_o) && $stable(added_spaces_o))
    else $error("result changed while stalled");

  a_err_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && status_o != ST_OK |->
      end_of_line_o && char_out_o == '0 && added_spaces_o == '0)
    else $error("malformed error transaction");

  a_line_added: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && pop && status_o == ST_OK && !end_of_line_o) ##1 !empty |->
      status_o == ST_OK && added_spaces_o == $past(added_spaces_o))
    else $error("padding count changed within a line");

endmodule

bind line_full_justify lfj_checker u_lfj_checker (.*);

@@ tb/sv/line_full_justify_tb.sv @@
// Self-checking testbench for line_full_justify: sends text lines, predicts the
// justified characters and error results, and checks each result transaction.
// Depends on lfj_pkg and the line_full_justify RTL.
module line_full_justify_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lfj_pkg::*;

  localparam int CYCLE_LIMIT  = 2_000_000;
  localparam int DRAIN_CYCLES = 200;
  localparam int MAX_BURST    = 18;

  typedef struct {
    logic [CHAR_W-1:0] ch;
    logic              eol;
    status_e           st;
    logic [TW_W-1:0]   added;
  } just_res_t;

  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              push          = 1'b0;
  logic              full;
  logic [CHAR_W-1:0] char_in_i     = '0;
  logic              is_last_i     = 1'b0;
  logic              cfg_we_i      = 1'b0;
  logic [TW_W-1:0]   cfg_wdata_i   = '0;
  logic              empty;
  logic              pop           = 1'b0;
  logic [CHAR_W-1:0] char_out_o;
  logic              end_of_line_o;
  logic [1:0]        status_o;
  logic [TW_W-1:0]   added_spaces_o;

  // justification state of the predictor
  logic [CHAR_W-1:0] line_mem [LINE_MAX];
  int                line_len    = 0;
  int                line_spaces = 0;
  bit                line_ovf    = 1'b0;
  int                target_w    = TARGET_RESET;

  just_res_t         justified_q[$];
  logic [CHAR_W-1:0] line_buf[$];
  just_res_t         exp_r;
  int                errors      = 0;
  int                chars_sent  = 0;
  int                cycle_count = 0;
  bit                calm        = 1'b0;

  line_full_justify dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .char_in_i      (char_in_i),
    .is_last_i      (is_last_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .empty          (empty),
    .pop            (pop),
    .char_out_o     (char_out_o),
    .end_of_line_o  (end_of_line_o),
    .status_o       (status_o),
    .added_spaces_o (added_spaces_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic int eff_target();
    return (target_w > OUT_MAX) ? OUT_MAX : target_w;
  endfunction

  task automatic justify_accept(input logic [CHAR_W-1:0] ch, input logic last);
    int        tgt;
    int        total;
    int        q;
    int        r;
    int        k;
    int        gap;
    int        n;
    just_res_t res;
    just_res_t out_q[$];
    if (line_len < LINE_MAX) begin
      line_mem[line_len] = ch;
      line_len++;
      if (ch == SPACE_CHAR) line_spaces++;
    end else begin
      line_ovf = 1'b1;
    end
    if (!last) return;
    tgt = eff_target();
    res.ch    = '0;
    res.eol   = 1'b1;
    res.added = '0;
    if (line_ovf || line_len > tgt) begin
      res.st = ST_LONG;
      out_q.push_back(res);
    end else if (line_spaces == 0) begin
      res.st = ST_NOWORD;
      out_q.push_back(res);
    end else begin
      total = tgt - line_len + line_spaces;
      q = total / line_spaces;
      r = total % line_spaces;
      k = 0;
      gap = 0;
      res.eol   = 1'b0;
      res.st    = ST_OK;
      res.added = TW_W'(tgt - line_len);
      for (int i = 0; i < line_len && k < tgt; i++) begin
        if (line_mem[i] != SPACE_CHAR) begin
          res.ch = line_mem[i];
          out_q.push_back(res);
          k++;
        end else begin
          n = q + ((gap < r) ? 1 : 0);
          gap++;
          res.ch = SPACE_CHAR;
          for (int j = 0; j < n && k < tgt; j++) begin
            out_q.push_back(res);
            k++;
          end
        end
      end
      out_q[out_q.size()-1].eol = 1'b1;
    end
    foreach (out_q[i]) justified_q.push_back(out_q[i]);
    line_len    = 0;
    line_spaces = 0;
    line_ovf    = 1'b0;
  endtask

  task automatic send_char(input logic [CHAR_W-1:0] ch, input logic last);
    if (!calm && $urandom_range(0, 5) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, MAX_BURST)) @(posedge clk_i);
    end
    push      <= 1'b1;
    char_in_i <= ch;
    is_last_i <= last;
    do @(posedge clk_i); while (full);
    chars_sent++;
    justify_accept(ch, last);
  endtask

  task automatic send_line();
    foreach (line_buf[i]) send_char(line_buf[i], i == line_buf.size() - 1);
  endtask

  task automatic send_text(input string s);
    line_buf.delete();
    for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
    send_line();
  endtask

  task automatic fill_line(input int len, input int space_pct, input bit need_space);
    logic [CHAR_W-1:0] b;
    line_buf.delete();
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 99) < space_pct) begin
        b = SPACE_CHAR;
      end else begin
        do b = CHAR_W'($urandom_range(0, 255)); while (b == SPACE_CHAR);
      end
      line_buf.push_back(b);
    end
    if (need_space) line_buf[$urandom_range(0, len - 1)] = SPACE_CHAR;
  endtask

  // hold the sender until every expected transaction has been popped
  task automatic wait_results();
    push <= 1'b0;
    while (justified_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic wait_idle();
    wait_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_target(input int v);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= TW_W'(v);
    @(posedge clk_i);
    target_w = v;
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic test_reset_target();
    send_text("ab cd");
  endtask

  task automatic test_gap_split();
    set_target(10);
    send_text("a b c");
    send_text("abcd efghi");
    send_text("x  y");
    send_text(" ab ");
  endtask

  task automatic test_error_cases();
    send_text("abcde fghij");
    send_text("abc");
    send_text(" ");
  endtask

  task automatic test_edge_bytes();
    line_buf.delete();
    line_buf.push_back(8'h00);
    line_buf.push_back(SPACE_CHAR);
    line_buf.push_back(8'hff);
    send_line();
  endtask

  task automatic test_target_extremes();
    set_target(0);
    send_text("a");
    set_target(127);
    send_text("x y");
    set_target(1);
    send_text(" ");
    send_text("a");
  endtask

  task automatic test_store_limits();
    set_target(64);
    fill_line(64, 15, 1'b1);
    send_line();
    fill_line(66, 15, 1'b1);
    send_line();
  endtask

  task automatic test_random_lines(input int tgt_cfg, input int n_items);
    int stop_at;
    int tgt;
    int mode;
    int len;
    set_target(tgt_cfg);
    tgt = (eff_target() < 1) ? 1 : eff_target();
    stop_at = chars_sent + n_items;
    while (chars_sent < stop_at) begin
      mode = $urandom_range(0, 9);
      len  = $urandom_range(1, tgt);
      if (len > stop_at - chars_sent) len = stop_at - chars_sent;
      if (mode <= 6) fill_line(len, $urandom_range(5, 35), 1'b1);
      else if (mode == 7) fill_line(eff_target() + $urandom_range(1, 6), 20, 1'b1);
      else if (mode == 8) fill_line(len, 0, 1'b0);
      else fill_line($urandom_range(1, 12), 50, 1'b0);
      send_line();
      if (!calm && $urandom_range(0, 11) == 0) wait_results();
    end
  endtask

  initial begin
    pop <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (!calm && $urandom_range(0, 7) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, MAX_BURST)) @(posedge clk_i);
      end
      pop <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && !empty && pop) begin
      if (justified_q.size() == 0) begin
        $error("unexpected result transaction: char_out %0d", char_out_o);
        errors++;
      end else begin
        exp_r = justified_q.pop_front();
        if (char_out_o !== exp_r.ch) begin
          $error("char_out expected %0d actual %0d", exp_r.ch, char_out_o);
          errors++;
        end
        if (end_of_line_o !== exp_r.eol) begin
          $error("end_of_line expected %0d actual %0d", exp_r.eol, end_of_line_o);
          errors++;
        end
        if (status_o !== exp_r.st) begin
          $error("status expected %0d actual %0d", exp_r.st, status_o);
          errors++;
        end
        if (added_spaces_o !== exp_r.added) begin
          $error("added_spaces expected %0d actual %0d", exp_r.added, added_spaces_o);
          errors++;
        end
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("line_full_justify: mismatch");
    $finish;
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_target();
    test_gap_split();
    test_error_cases();
    test_edge_bytes();
    test_target_extremes();
    test_store_limits();
    test_random_lines(64, 20);
    test_random_lines(23, 15);
    test_random_lines(127, 12);
    test_random_lines(5, 10);
    test_random_lines(0, 6);
    calm = 1'b1;
    test_random_lines(60, 20);
    wait_idle();
    if (errors == 0) begin
      $display("line_full_justify: match");
    end else begin
      $display("line_full_justify: mismatch");
    end
    $finish;
  end

endmodule
